@@ hw/rtl/fconv3_pkg.sv @@
`default_nettype none

package fconv3_pkg;

  // grid limits and sample format
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_BITS    = 16;
  localparam int CONV_BITS   = 35;
  localparam int IDX_BITS    = 7;
  localparam int GEOM_BITS   = 7;
  localparam int STEP_BITS   = 3;
  localparam int CFG_BITS    = 64;
  localparam int CFG_IDX_BITS = 3;

  // counter and index widths
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int MAX_DIM = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
  localparam int DB = $clog2(MAX_DIM + 2);

  // divide by three through a reciprocal, exact for values below 2**DB
  localparam int DIV_K     = DB + 2;
  localparam int DIV_RECIP = ((2 ** DIV_K) + 2) / 3;

  // arithmetic widths
  localparam int PROD_BITS = SAMPLE_BITS + TAP_BITS;
  localparam int PSUM_BITS = PROD_BITS + 2;
  localparam int SUM_BITS  = (PROD_BITS + 4 > CONV_BITS) ? PROD_BITS + 4 : CONV_BITS;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAB    = $clog2(QDEPTH);
  localparam int QCB    = $clog2(QDEPTH + 1);

  // stream word widths
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = CONV_BITS + 2 * IDX_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_HEIGHT,
    REG_GRID_WIDTH,
    REG_STEP_SIZE,
    REG_TAPS_FIRST,
    REG_TAPS_SECOND,
    REG_TAP_FINAL
  } reg_index_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TAP_BITS-1:0] tap_t;
  typedef tap_t [8:0] taps_t;
  typedef sample_t [8:0] window_t;

  // grid geometry as written
  typedef struct packed {
    logic [GEOM_BITS-1:0] grid_height;
    logic [GEOM_BITS-1:0] grid_width;
    logic [STEP_BITS-1:0] step_size;
  } geom_t;

  // one classified sample: its window and the outputs it completes
  typedef struct packed {
    window_t                   win;
    logic [2:0]                rmask;
    logic [2:0]                cmask;
    logic [2:0][IDX_BITS-1:0]  orow;
    logic [2:0][IDX_BITS-1:0]  ocol;
  } job_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } bitpos_t;

  // quotient of a padded position by the stride (1 to 4)
  function automatic logic [DB-1:0] step_div(input logic [DB-1:0] v,
                                             input logic [STEP_BITS-1:0] s);
    logic [DB+DIV_K-1:0] prod;
    logic [DB-1:0]       q;
    prod = (DB + DIV_K)'(v) * (DB + DIV_K)'(DIV_RECIP);
    case (s)
      3'd2:    q = v >> 1;
      3'd3:    q = prod[DB+DIV_K-1:DIV_K];
      3'd4:    q = v >> 2;
      default: q = v;
    endcase
    return q;
  endfunction

  // lowest set bit of a nonzero offset mask
  function automatic logic [1:0] first_bit(input logic [2:0] m);
    logic [1:0] p;
    if (m[0]) p = 2'd0;
    else if (m[1]) p = 2'd1;
    else p = 2'd2;
    return p;
  endfunction

  // next set bit above position p
  function automatic bitpos_t next_bit(input logic [2:0] m, input logic [1:0] p);
    bitpos_t r;
    r = '0;
    if (p == 2'd0 && m[1]) begin
      r.found = 1'b1;
      r.idx   = 2'd1;
    end else if (p != 2'd2 && m[2]) begin
      r.found = 1'b1;
      r.idx   = 2'd2;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fconv3_ram.sv @@
`default_nettype none

module fconv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fconv3_front.sv @@
`default_nettype none

module fconv3_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire fconv3_pkg::sample_t     in_sample,
  input  wire fconv3_pkg::geom_t       geom,
  input  wire logic [fconv3_pkg::QCB-1:0] q_count,
  output logic                         push,
  output fconv3_pkg::job_t             job
);
  import fconv3_pkg::*;

  logic [HB-1:0] h;
  logic [WB-1:0] w;
  logic [STEP_BITS-1:0] s;
  logic [RB-1:0] rlim, r, row_count;
  logic [CB-1:0] clim, c, col_count;
  logic last_row, last_col, accept, fwd_now;
  logic [2:0] rmask, cmask;
  logic [2:0][IDX_BITS-1:0] orow, ocol;

  logic s1_valid, s1_col0, s1_r1, s1_r2, s1_fwd;
  sample_t s1_sample, fwd_mid, fwd_top, mid_rd, top_rd, mid_eff, top_eff;
  logic [CB-1:0] s1_col;
  logic [2:0] s1_rmask, s1_cmask;
  logic [2:0][IDX_BITS-1:0] s1_orow, s1_ocol;
  window_t window, base, win_next;

  // clamp the geometry into its legal range
  always_comb begin
    if (geom.grid_height == '0) h = HB'(1);
    else if (32'(geom.grid_height) > MAX_HEIGHT) h = HB'(MAX_HEIGHT);
    else h = HB'(geom.grid_height);
    if (geom.grid_width == '0) w = WB'(1);
    else if (32'(geom.grid_width) > MAX_WIDTH) w = WB'(MAX_WIDTH);
    else w = WB'(geom.grid_width);
    if (geom.step_size == '0) s = STEP_BITS'(1);
    else if (geom.step_size > STEP_BITS'(4)) s = STEP_BITS'(4);
    else s = geom.step_size;
  end

  // position of the incoming sample
  assign rlim     = RB'(h - HB'(1));
  assign clim     = CB'(w - WB'(1));
  assign r        = (row_count < rlim) ? row_count : rlim;
  assign c        = (col_count < clim) ? col_count : clim;
  assign last_row = (r == rlim);
  assign last_col = (c == clim);

  // classify: which padded rows and columns close a window on the stride grid
  always_comb begin
    logic [DB-1:0] pr, pc, qr, qc, mr, mc;
    for (int d = 0; d < 3; d++) begin
      pr = DB'(r) + DB'(d);
      pc = DB'(c) + DB'(d);
      qr = step_div(pr, s);
      qc = step_div(pc, s);
      mr = pr - DB'(qr * DB'(s));
      mc = pc - DB'(qc * DB'(s));
      rmask[d] = (d == 0 || last_row) && (mr == '0);
      cmask[d] = (d == 0 || last_col) && (mc == '0);
      orow[d]  = IDX_BITS'(qr);
      ocol[d]  = IDX_BITS'(qc);
    end
  end

  // room for this word and the one still in the line stage
  assign in_ready = ({1'b0, q_count} + {{QCB{1'b0}}, s1_valid}) < (QCB + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign fwd_now  = s1_valid && (s1_col == c);

  // line stores: previous row and the row before it
  fconv3_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_mid_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_sample),
    .re    (accept),
    .raddr (c),
    .rdata (mid_rd)
  );

  fconv3_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_top_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid_eff),
    .re    (accept),
    .raddr (c),
    .rdata (top_rd)
  );

  // bypass when the line entry is written in the same cycle it is read
  assign mid_eff = s1_fwd ? fwd_mid : mid_rd;
  assign top_eff = s1_fwd ? fwd_top : top_rd;

  // position counters and line-stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : r + RB'(1);
        end else begin
          col_count <= c + CB'(1);
          row_count <= r;
        end
      end
    end
  end

  // line-stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= in_sample;
      s1_col    <= c;
      s1_col0   <= (c == '0);
      s1_r1     <= (r >= RB'(1));
      s1_r2     <= (r >= RB'(2));
      s1_fwd    <= fwd_now;
      s1_rmask  <= rmask;
      s1_cmask  <= cmask;
      s1_orow   <= orow;
      s1_ocol   <= ocol;
      fwd_mid   <= s1_sample;
      fwd_top   <= mid_eff;
    end
  end

  // window shift, cleared at the start of each row
  always_comb begin
    base = s1_col0 ? '0 : window;
    win_next[0] = base[1];
    win_next[1] = base[2];
    win_next[2] = s1_r2 ? top_eff : '0;
    win_next[3] = base[4];
    win_next[4] = base[5];
    win_next[5] = s1_r1 ? mid_eff : '0;
    win_next[6] = base[7];
    win_next[7] = base[8];
    win_next[8] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      window <= win_next;
    end
  end

  // hand the classified word to the queue
  assign push      = s1_valid;
  assign job.win   = win_next;
  assign job.rmask = s1_rmask;
  assign job.cmask = s1_cmask;
  assign job.orow  = s1_orow;
  assign job.ocol  = s1_ocol;

endmodule

`default_nettype wire

@@ hw/rtl/fconv3_queue.sv @@
`default_nettype none

module fconv3_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire fconv3_pkg::job_t           push_job,
  input  wire logic                       pop,
  output fconv3_pkg::job_t                head_job,
  output logic                            head_valid,
  output logic [fconv3_pkg::QCB-1:0]      count
);
  import fconv3_pkg::*;

  job_t slots [QDEPTH];
  logic [QAB-1:0] wptr, rptr;

  assign head_job   = slots[rptr];
  assign head_valid = (count != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAB'(QDEPTH - 1)) ? '0 : wptr + QAB'(1);
      end
      if (pop) begin
        rptr <= (rptr == QAB'(QDEPTH - 1)) ? '0 : rptr + QAB'(1);
      end
      count <= count + QCB'(push) - QCB'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fconv3_back.sv @@
`default_nettype none

module fconv3_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fconv3_pkg::job_t             head_job,
  input  wire logic                         head_valid,
  output logic                              pop,
  input  wire fconv3_pkg::taps_t            taps,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [fconv3_pkg::CONV_BITS-1:0]  out_value,
  output logic [fconv3_pkg::IDX_BITS-1:0]   out_row,
  output logic [fconv3_pkg::IDX_BITS-1:0]   out_col,
  output logic                              out_last
);
  import fconv3_pkg::*;

  logic en, empty, issue, last, started;
  logic [1:0] d, e, dcur, ecur;
  bitpos_t ne, nd;

  logic m_valid, m_last;
  logic [IDX_BITS-1:0] m_row, m_col;
  logic signed [PROD_BITS-1:0] m_prod [9];
  logic signed [PROD_BITS-1:0] prod_c [9];

  logic p_valid, p_last;
  logic [IDX_BITS-1:0] p_row, p_col;
  logic signed [PSUM_BITS-1:0] p_sum [3];
  logic signed [SUM_BITS-1:0] sum_c;

  // whole back pipeline moves when the output word can advance
  assign en = !out_valid || out_ready;

  // walk the completed windows of the head word in raster order
  assign empty = (head_job.rmask == '0) || (head_job.cmask == '0);
  assign d     = started ? dcur : first_bit(head_job.rmask);
  assign e     = started ? ecur : first_bit(head_job.cmask);
  assign ne    = next_bit(head_job.cmask, e);
  assign nd    = next_bit(head_job.rmask, d);
  assign last  = !ne.found && !nd.found;
  assign issue = head_valid && en && !empty;
  assign pop   = head_valid && en && (empty || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (issue) begin
      if (last) begin
        started <= 1'b0;
      end else begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      if (ne.found) begin
        dcur <= d;
        ecur <= ne.idx;
      end else begin
        dcur <= nd.idx;
        ecur <= first_bit(head_job.cmask);
      end
    end
  end

  // products: window cells beyond the offset meet the rotated kernel
  always_comb begin
    int   ti;
    tap_t tv;
    for (int wr = 0; wr < 3; wr++) begin
      for (int wc = 0; wc < 3; wc++) begin
        ti = (2 - wr + int'(d)) * 3 + (2 - wc + int'(e));
        if ((wr >= int'(d)) && (wc >= int'(e))) begin
          tv = taps[ti[3:0]];
        end else begin
          tv = '0;
        end
        prod_c[wr*3+wc] = head_job.win[wr*3+wc] * tv;
      end
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= issue;
      p_valid   <= m_valid;
      out_valid <= p_valid;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= prod_c;
      m_row  <= head_job.orow[d];
      m_col  <= head_job.ocol[e];
      m_last <= last;
    end
  end

  // row partial sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_sum[k] <= PSUM_BITS'(m_prod[3*k]) + PSUM_BITS'(m_prod[3*k+1])
                  + PSUM_BITS'(m_prod[3*k+2]);
      end
      p_row  <= m_row;
      p_col  <= m_col;
      p_last <= m_last;
    end
  end

  // final sum into the output word
  assign sum_c = SUM_BITS'(p_sum[0]) + SUM_BITS'(p_sum[1]) + SUM_BITS'(p_sum[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= sum_c[CONV_BITS-1:0];
      out_row   <= p_row;
      out_col   <= p_col;
      out_last  <= p_last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/full_convolution_3x3_padded_unit.sv @@
`default_nettype none

// Full 3x3 convolution of a zero-padded grid, streamed one Q4.12 sample per
// word in raster order; results are exact Q11.24 sums with their output row
// and column, tlast marking the last result caused by a sample. The input
// side takes one sample per cycle. Each sample then becomes one job that the
// back-end multiply pipeline works through one window at a time: one window
// inside a row, up to three at a row end, up to nine in the last row (fewer
// with a larger stride). A four-word job queue absorbs these bursts; when
// the queue and the line stage together hold four words, s_axis_tready
// drops until the back end catches up. With the queue empty and the output
// not stalled, a sample's first result passes the line stage, the job queue
// and the product, partial-sum and output registers.
// Two line stores of MAX_WIDTH samples each hold the previous two rows.
// Configure geometry, stride and taps only while the block is idle.
module full_convolution_3x3_padded_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // sample_value
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  wire logic [fconv3_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // conv_value, out_row, out_col, zero fill
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output logic [fconv3_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
  // run_last
  output logic                                        m_axis_tlast,
  input  wire logic                                   cfg_write,
  input  wire logic [fconv3_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [fconv3_pkg::CFG_BITS-1:0]        cfg_data
);
  import fconv3_pkg::*;

  geom_t geom;
  logic [CFG_BITS-1:0] taps_first, taps_second;
  tap_t tap_final;
  taps_t taps;

  logic push, pop, head_valid;
  job_t push_job, head_job;
  logic [QCB-1:0] q_count;
  logic [CONV_BITS-1:0] conv_value;
  logic [IDX_BITS-1:0] out_row, out_col;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.grid_height <= GEOM_BITS'(64);
      geom.grid_width  <= GEOM_BITS'(64);
      geom.step_size   <= STEP_BITS'(1);
      taps_first       <= '0;
      taps_second      <= '0;
      tap_final        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_HEIGHT: geom.grid_height <= cfg_data[GEOM_BITS-1:0];
        REG_GRID_WIDTH:  geom.grid_width  <= cfg_data[GEOM_BITS-1:0];
        REG_STEP_SIZE:   geom.step_size   <= cfg_data[STEP_BITS-1:0];
        REG_TAPS_FIRST:  taps_first       <= cfg_data;
        REG_TAPS_SECOND: taps_second      <= cfg_data;
        REG_TAP_FINAL:   tap_final        <= cfg_data[TAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // unpack the kernel taps, row-major
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      taps[t]     = taps_first[t*TAP_BITS +: TAP_BITS];
      taps[t + 4] = taps_second[t*TAP_BITS +: TAP_BITS];
    end
    taps[8] = tap_final;
  end

  fconv3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .geom      (geom),
    .q_count   (q_count),
    .push      (push),
    .job       (push_job)
  );

  fconv3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .count      (q_count)
  );

  fconv3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .taps       (taps),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (conv_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (m_axis_tlast)
  );

  // pack the result word
  assign m_axis_tdata = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}}, out_col, out_row,
                         conv_value};

endmodule

`default_nettype wire

@@ sim/full_convolution_3x3_padded_unit_tb.sv @@
`timescale 1ns / 100ps

module full_convolution_3x3_padded_unit_tb;
  import fconv3_pkg::*;

  // one result word as the block should send it
  typedef struct packed {
    logic [CONV_BITS-1:0] sum;
    logic [IDX_BITS-1:0]  row;
    logic [IDX_BITS-1:0]  col;
    logic                 last;
  } conv_result_t;

  // full 3x3 convolution predictor plus the queue of sums still owed
  class conv3_checker;
    int           line_prev[MAX_WIDTH];
    int           line_older[MAX_WIDTH];
    int           win[9];
    int           kern[9];
    int unsigned  row_cnt;
    int unsigned  col_cnt;
    logic [GEOM_BITS-1:0] height_reg;
    logic [GEOM_BITS-1:0] width_reg;
    logic [STEP_BITS-1:0] stride_reg;
    conv_result_t expected_sums[$];
    int unsigned  errors;

    function new();
      height_reg = GEOM_BITS'(64);
      width_reg  = GEOM_BITS'(64);
      stride_reg = STEP_BITS'(1);
      row_cnt    = 0;
      col_cnt    = 0;
      errors     = 0;
      foreach (kern[k]) kern[k] = 0;
      foreach (win[k]) win[k] = 0;
      foreach (line_prev[k]) begin
        line_prev[k]  = 0;
        line_older[k] = 0;
      end
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_BITS-1:0] v);
      tap_t t;
      case (idx)
        REG_GRID_HEIGHT: height_reg = v[GEOM_BITS-1:0];
        REG_GRID_WIDTH:  width_reg  = v[GEOM_BITS-1:0];
        REG_STEP_SIZE:   stride_reg = v[STEP_BITS-1:0];
        REG_TAPS_FIRST: begin
          for (int k = 0; k < 4; k++) begin
            t = v[16*k +: 16];
            kern[k] = t;
          end
        end
        REG_TAPS_SECOND: begin
          for (int k = 0; k < 4; k++) begin
            t = v[16*k +: 16];
            kern[4+k] = t;
          end
        end
        REG_TAP_FINAL: begin
          t = v[15:0];
          kern[8] = t;
        end
        default: ;
      endcase
    endfunction

    // geometry as the block applies it, out-of-range values saturated
    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_stride();
      if (stride_reg == 0) return 1;
      if (stride_reg > 4) return 4;
      return stride_reg;
    endfunction

    function bit mid_frame();
      return (row_cnt != 0) || (col_cnt != 0);
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // window rows/cols beyond the current sample are padding and drop out
    function logic [CONV_BITS-1:0] window_sum(int d, int e);
      longint acc;
      int     wr;
      int     wc;
      acc = 0;
      for (int fi = 0; fi < 3; fi++) begin
        for (int fj = 0; fj < 3; fj++) begin
          wr = d + fi;
          wc = e + fj;
          if (wr <= 2 && wc <= 2)
            acc += longint'(win[wr*3+wc]) * longint'(kern[(2-fi)*3+(2-fj)]);
        end
      end
      return acc[CONV_BITS-1:0];
    endfunction

    // accepted sample: shift lines and window, queue every window it completes
    function void take_sample(logic [SAMPLE_BITS-1:0] raw);
      sample_t      sv;
      int           smp;
      int           top;
      int           mid;
      int           n;
      int unsigned  h, w, s, r, c, pr, pc, dmax, emax;
      conv_result_t burst[9];
      sv  = raw;
      smp = sv;
      h   = eff_height();
      w   = eff_width();
      s   = eff_stride();
      r   = (row_cnt < h - 1) ? row_cnt : h - 1;
      c   = (col_cnt < w - 1) ? col_cnt : w - 1;

      top = (r >= 2) ? line_older[c] : 0;
      mid = (r >= 1) ? line_prev[c] : 0;
      line_older[c] = line_prev[c];
      line_prev[c]  = smp;

      if (c == 0) foreach (win[k]) win[k] = 0;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = smp;

      // last row and last column also close the windows hanging into padding
      dmax = (r == h - 1) ? 2 : 0;
      emax = (c == w - 1) ? 2 : 0;
      n = 0;
      for (int unsigned d = 0; d <= dmax; d++) begin
        pr = r + d;
        if (pr % s == 0) begin
          for (int unsigned e = 0; e <= emax; e++) begin
            pc = c + e;
            if (pc % s == 0) begin
              burst[n].sum  = window_sum(d, e);
              burst[n].row  = IDX_BITS'(pr / s);
              burst[n].col  = IDX_BITS'(pc / s);
              burst[n].last = 1'b0;
              n++;
            end
          end
        end
      end
      if (n > 0) burst[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) expected_sums = {expected_sums, burst[k]};

      if (c >= w - 1) begin
        col_cnt = 0;
        row_cnt = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    function void report(string what, conv_result_t want, conv_result_t got);
      errors++;
      if (errors <= 10)
        $display("%0t: %s: want sum %0d r %0d c %0d l %0b, got sum %0d r %0d c %0d l %0b",
                 $realtime, what, $signed(want.sum), want.row, want.col, want.last,
                 $signed(got.sum), got.row, got.col, got.last);
    endfunction

    // compare one output word against the oldest owed result
    function void check_word(logic [OUT_DATA_BITS-1:0] d, logic tl);
      conv_result_t got;
      conv_result_t want;
      got.sum  = d[CONV_BITS-1:0];
      got.row  = d[CONV_BITS +: IDX_BITS];
      got.col  = d[CONV_BITS+IDX_BITS +: IDX_BITS];
      got.last = tl;
      if (expected_sums.size() == 0) begin
        want = '0;
        report("unexpected word", want, got);
        return;
      end
      want = expected_sums.pop_front();
      if (got !== want) report("mismatch", want, got);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [IN_DATA_BITS-1:0]    s_axis_tdata;   // sample_value
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [OUT_DATA_BITS-1:0]   m_axis_tdata;   // conv_value, out_row, out_col, zero fill
  logic                       m_axis_tlast;   // run_last
  logic                       cfg_write;
  logic [CFG_IDX_BITS-1:0]    cfg_index;
  logic [CFG_BITS-1:0]        cfg_data;

  conv3_checker sb;
  int           sent;
  int           burst_left;
  bit           valid_up;

  localparam int SETTLE_CYCLES = 48;

  full_convolution_3x3_padded_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(64'd20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // output side stalls in spans of varying character
  initial begin : rx_stall
    int mode;
    int span;
    m_axis_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 5) != 0);
          3:       m_axis_tready <= ((k % 7) < 3);
          default: m_axis_tready <= (k >= span / 2);
        endcase
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && sb != null && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  task automatic stop_sending();
    if (valid_up) begin
      s_axis_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // one sample word, with burst gaps drawn here
  task automatic send_word(logic [SAMPLE_BITS-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        stop_sending();
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    valid_up = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_sample(v);
    sent++;
  endtask

  // hold the input until every owed result has come out
  task automatic drain_outputs();
    stop_sending();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(reg_index_t idx, logic [CFG_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic configure(int h, int w, int s, logic [63:0] taps_lo,
                           logic [63:0] taps_hi, logic [15:0] tap_last);
    write_cfg(REG_GRID_HEIGHT, CFG_BITS'(h));
    write_cfg(REG_GRID_WIDTH, CFG_BITS'(w));
    write_cfg(REG_STEP_SIZE, CFG_BITS'(s));
    write_cfg(REG_TAPS_FIRST, taps_lo);
    write_cfg(REG_TAPS_SECOND, taps_hi);
    write_cfg(REG_TAP_FINAL, CFG_BITS'(tap_last));
    cfg_write <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] corner[5];
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 4)];
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic logic [63:0] pick_taps();
    case ($urandom_range(0, 5))
      0:       return 64'h8000_8000_8000_8000;
      1:       return 64'h7fff_7fff_7fff_7fff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_samples(int count);
    for (int k = 0; k < count; k++) begin
      send_word(pick_sample());
      if ($urandom_range(0, 59) == 0) drain_outputs();
    end
  endtask

  // runs to the end of the current grid, a whole grid when at its start
  task automatic finish_frame();
    do begin
      send_word(pick_sample());
      if ($urandom_range(0, 59) == 0) drain_outputs();
    end while (sb.mid_frame());
  endtask

  // stimulus
  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] walk[9];
    int h;
    int w;
    sb = new();
    sent       = 0;
    burst_left = 0;
    valid_up   = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_GRID_HEIGHT;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single-sample grids, most negative taps: every window, extreme products
    configure(1, 1, 1, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 16'h8000);
    send_word(16'h8000);
    send_word(16'h7fff);
    send_word(16'h0000);
    send_word(16'hffff);

    // zero geometry and stride saturate up to one
    settle();
    configure(0, 0, 0, 64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff, 16'h7fff);
    send_word(16'h7fff);
    send_word(16'h8000);

    // 3x3 grid at stride two, mixed taps
    settle();
    configure(3, 3, 2, 64'h8000_7fff_0001_ffff, 64'h1234_edcc_4000_c000, 16'h0800);
    walk = '{16'h0001, 16'h8000, 16'h7fff, 16'h0100, 16'hff00,
             16'h1234, 16'hedcc, 16'h0000, 16'h4000};
    foreach (walk[k]) send_word(walk[k]);

    // grid shrinks mid-frame so both counters sit beyond the new size
    settle();
    configure(4, 5, 3, pick_taps(), pick_taps(), 16'h8001);
    for (int k = 0; k < 8; k++) send_word(pick_sample());
    settle();
    configure(1, 2, 3, pick_taps(), pick_taps(), 16'h7ffe);
    send_word(16'h5a5a);

    // tallest grid, one column, stride saturating to four
    settle();
    configure(127, 1, 7, pick_taps(), pick_taps(), 16'($urandom));
    send_samples(20);
    drain_outputs();
    finish_frame();

    // widest grid in a single row
    settle();
    configure(1, 100, 1, pick_taps(), pick_taps(), 16'($urandom));
    finish_frame();

    // random small grids, some cut short and shrunk mid-frame
    while (sent < 460) begin
      settle();
      if (sb.mid_frame()) w = $urandom_range(1, sb.eff_width());
      else w = $urandom_range(0, 10);
      h = $urandom_range(0, 8);
      configure(h, w, $urandom_range(0, 7), pick_taps(), pick_taps(), 16'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        send_samples($urandom_range(1, 12));
      end else begin
        finish_frame();
        if ($urandom_range(0, 2) == 0) finish_frame();
      end
    end

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
